// ===== rtl/assert_macros.svh =====
// Assertion helpers shared by the RTL modules.
// Every macro samples on clk and is disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that expr holds at every clock edge.
`define ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// Check that cons holds in the same cycle as ante.
`define ASSERT_IMPLY(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/rtloc_pkg.sv =====
// ----------------------------------------------------------------------------
// rtloc_pkg
// Shared types and constants for the relocation table locator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rtloc_pkg;

	localparam int POS_W = 24;
	localparam int NEXT_W = 26;
	localparam int OFFSET_W = 27;
	localparam logic [POS_W:0] MAX_IMAGE_WORDS = 25'd16777216;

	localparam logic [63:0] TYPE_RELATIVE = 64'h403;
	localparam logic [63:0] TYPE_ABS = 64'h101;
	localparam logic [11:0] TYPE_ABS_LOW = 12'h101;

	localparam logic [63:0] ADDR_FLOOR_RST = 64'hffff_ff80_0000_0000;
	localparam logic [5:0] RUN_THRESHOLD_RST = 6'd50;
	localparam logic [2:0] GAP_LIMIT_RST = 3'd5;

	localparam int ITEM_QUEUE_DEPTH = 4;
	localparam int ITEM_PTR_W = 2;
	localparam int RESULT_QUEUE_DEPTH = 4;
	localparam int RESULT_PTR_W = 2;

	typedef enum logic [1:0] {
		CFG_ADDR_FLOOR = 2'd0,
		CFG_RUN_THRESHOLD = 2'd1,
		CFG_GAP_LIMIT = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		EV_START = 2'd0,
		EV_END = 2'd1,
		EV_NONE = 2'd2
	} ev_code_t;

	typedef struct packed {
		logic pos_ok;
		logic last;
		logic exact;
		logic loose;
		logic addr_ok;
		logic [POS_W-1:0] pos;
	} item_t;

	typedef struct packed {
		ev_code_t code;
		logic [OFFSET_W-1:0] offset;
		logic final_result;
	} result_t;

	typedef struct packed {
		logic [1:0] count;
		result_t r0;
		result_t r1;
	} res_wr_t;

endpackage

// ===== rtl/relocation_table_locator_core.sv =====
// ----------------------------------------------------------------------------
// relocation_table_locator_core
// Scans a 64-bit image word stream for a relocation record table.
// ----------------------------------------------------------------------------
// Results of a word pass the item queue and then the result queue, both registered.
// Throughput: one word per cycle while the item queue is not full and the
// result queue has room for two; the back's match-count and next-record
// update is made once per word.
// Up to two results per word; the result queue drains one per cycle while pop is high.
// Reset: asynchronous; clears the search and queues, loads register defaults.
`timescale 1ns / 1ps

module relocation_table_locator_core (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic [63:0] image_word,
	input  logic last_word,
	output logic empty,
	input  logic pop,
	output rtloc_pkg::ev_code_t event_code,
	output logic [26:0] byte_offset,
	output logic final_result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [63:0] cfg_data
);
	import rtloc_pkg::*;

	logic [63:0] addr_floor_q;
	logic [5:0] run_threshold_q;
	logic [2:0] gap_limit_q;

	item_t front_item;
	item_t back_item;
	logic item_empty;
	logic item_pop;
	logic room2;
	res_wr_t res_wr;
	result_t head;
	logic accept;

	assign cfg_ready = 1'b1;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_floor_q <= ADDR_FLOOR_RST;
			run_threshold_q <= RUN_THRESHOLD_RST;
			gap_limit_q <= GAP_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_ADDR_FLOOR: addr_floor_q <= cfg_data;
				CFG_RUN_THRESHOLD: run_threshold_q <= cfg_data[5:0];
				CFG_GAP_LIMIT: gap_limit_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	rtloc_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.image_word(image_word),
		.last_word(last_word),
		.addr_floor(addr_floor_q),
		.item(front_item)
	);

	rtloc_item_queue u_item_queue (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(accept),
		.wr_item(front_item),
		.full(full),
		.rd_en(item_pop),
		.rd_item(back_item),
		.empty(item_empty)
	);

	rtloc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.item(back_item),
		.item_empty(item_empty),
		.item_pop(item_pop),
		.room2(room2),
		.run_threshold(run_threshold_q),
		.gap_limit(gap_limit_q),
		.res_wr(res_wr)
	);

	rtloc_result_queue u_result_queue (
		.clk(clk),
		.arst_n(arst_n),
		.res_wr(res_wr),
		.room2(room2),
		.pop(pop),
		.empty(empty),
		.head(head)
	);

	assign event_code = head.code;
	assign byte_offset = head.offset;
	assign final_result = head.final_result;

endmodule

// ===== rtl/rtloc_front.sv =====
// ----------------------------------------------------------------------------
// rtloc_front
// Word window, position counter and record type classification.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rtloc_front (
	input  logic clk,
	input  logic arst_n,
	input  logic accept,
	input  logic [63:0] image_word,
	input  logic last_word,
	input  logic [63:0] addr_floor,
	output rtloc_pkg::item_t item
);
	import rtloc_pkg::*;

	logic [63:0] w1_q;
	logic [63:0] w2_q;
	logic [POS_W:0] pos_q;
	logic pos_ok;

	assign pos_ok = pos_q < MAX_IMAGE_WORDS;

	always_comb begin
		item.pos_ok = pos_ok;
		item.last = last_word;
		item.exact = (w2_q == TYPE_RELATIVE) || (w2_q == TYPE_ABS);
		item.loose = item.exact || (w2_q[11:0] == TYPE_ABS_LOW);
		item.addr_ok = (w1_q >= addr_floor) && (image_word >= addr_floor);
		item.pos = pos_q[POS_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w1_q <= '0;
			w2_q <= '0;
			pos_q <= '0;
		end else if (accept) begin
			if (last_word) begin
				w1_q <= '0;
				w2_q <= '0;
				pos_q <= '0;
			end else if (pos_ok) begin
				w1_q <= w2_q;
				w2_q <= image_word;
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

// ===== rtl/rtloc_item_queue.sv =====
// ----------------------------------------------------------------------------
// rtloc_item_queue
// Short queue of classified words between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtloc_item_queue (
	input  logic clk,
	input  logic arst_n,
	input  logic wr_en,
	input  rtloc_pkg::item_t wr_item,
	output logic full,
	input  logic rd_en,
	output rtloc_pkg::item_t rd_item,
	output logic empty
);
	import rtloc_pkg::*;

	item_t mem_q [ITEM_QUEUE_DEPTH];
	logic [ITEM_PTR_W-1:0] wr_ptr_q;
	logic [ITEM_PTR_W-1:0] rd_ptr_q;
	logic [ITEM_PTR_W:0] cnt_q;

	assign full = cnt_q == (ITEM_PTR_W+1)'(ITEM_QUEUE_DEPTH);
	assign empty = cnt_q == '0;
	assign rd_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (wr_en && !rd_en) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	`ASSERT_ALWAYS(a_item_cnt_bound, cnt_q <= (ITEM_PTR_W+1)'(ITEM_QUEUE_DEPTH), "item queue overflow")
	`ASSERT_IMPLY(a_item_no_underflow, rd_en, !empty, "item queue read while empty")

endmodule

// ===== rtl/rtloc_back.sv =====
// ----------------------------------------------------------------------------
// rtloc_back
// Record judging, run and gap counting, and result generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtloc_back (
	input  logic clk,
	input  logic arst_n,
	input  rtloc_pkg::item_t item,
	input  logic item_empty,
	output logic item_pop,
	input  logic room2,
	input  logic [5:0] run_threshold,
	input  logic [2:0] gap_limit,
	output rtloc_pkg::res_wr_t res_wr
);
	import rtloc_pkg::*;

	typedef enum logic [1:0] {
		PH_START,
		PH_END,
		PH_DONE
	} phase_t;

	phase_t phase_q;
	logic [NEXT_W-1:0] next_q;
	logic [5:0] mc_q;
	logic [2:0] gap_q;
	logic [POS_W-1:0] gsp_q;

	phase_t phase_d;
	logic [NEXT_W-1:0] next_d;
	logic [5:0] mc_d;
	logic [2:0] gap_d;
	logic [POS_W-1:0] gsp_d;

	logic judge;
	logic [5:0] thr;
	logic [2:0] gthr;
	logic [5:0] mc_new;
	logic [2:0] gap_new;
	logic [5:0] thr_m1;
	logic [7:0] back_words;
	logic [POS_W-1:0] first;
	logic j_emit;
	logic none_emit;
	result_t j_res;
	result_t none_res;

	assign item_pop = !item_empty && room2;
	assign judge = item.pos_ok && (phase_q != PH_DONE)
		&& ({2'b00, item.pos} == next_q + NEXT_W'(2));
	assign thr = (run_threshold == '0) ? 6'd1 : run_threshold;
	assign gthr = (gap_limit == '0) ? 3'd1 : gap_limit;
	assign thr_m1 = thr - 6'd1;
	assign back_words = {1'b0, thr_m1, 1'b0} + {2'b00, thr_m1};
	assign first = next_q[POS_W-1:0] - {16'b0, back_words};
	assign gap_new = gap_q + 3'd1;

	always_comb begin
		phase_d = phase_q;
		next_d = next_q;
		mc_d = mc_q;
		gap_d = gap_q;
		gsp_d = gsp_q;
		j_emit = 1'b0;
		j_res.code = EV_START;
		j_res.offset = {first, 3'b000};
		j_res.final_result = 1'b0;
		mc_new = mc_q;
		if (item.exact) begin
			if (item.addr_ok) begin
				mc_new = mc_q + 6'd1;
			end
		end else if (item.loose) begin
			mc_new = mc_q + 6'd1;
		end else begin
			mc_new = '0;
		end
		if (judge) begin
			if (phase_q == PH_START) begin
				mc_d = mc_new;
				if (mc_new == thr) begin
					j_emit = 1'b1;
					phase_d = PH_END;
					gap_d = '0;
					next_d = next_q + NEXT_W'(3);
				end else begin
					next_d = next_q + ((mc_new != '0) ? NEXT_W'(3) : NEXT_W'(1));
				end
			end else begin
				if (item.loose) begin
					gap_d = '0;
				end else begin
					if (gap_q == '0) begin
						gsp_d = next_q[POS_W-1:0];
					end
					gap_d = gap_new;
					if (gap_new >= gthr) begin
						j_emit = 1'b1;
						j_res.code = EV_END;
						j_res.offset = {((gap_q == '0) ? next_q[POS_W-1:0] : gsp_q), 3'b000};
						phase_d = PH_DONE;
					end
				end
				next_d = next_q + NEXT_W'(3);
			end
		end
		none_emit = item.last && (phase_d != PH_DONE);
		none_res.code = EV_NONE;
		none_res.offset = '0;
		none_res.final_result = 1'b1;
		if (item.last) begin
			phase_d = PH_START;
			next_d = '0;
			mc_d = '0;
			gap_d = '0;
			gsp_d = '0;
		end
		res_wr.count = 2'(j_emit) + 2'(none_emit);
		res_wr.r0 = j_emit ? j_res : none_res;
		res_wr.r0.final_result = !(j_emit && none_emit);
		res_wr.r1 = none_res;
		if (!item_pop) begin
			res_wr.count = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			next_q <= '0;
			mc_q <= '0;
			gap_q <= '0;
			gsp_q <= '0;
		end else if (item_pop) begin
			phase_q <= phase_d;
			next_q <= next_d;
			mc_q <= mc_d;
			gap_q <= gap_d;
			gsp_q <= gsp_d;
		end
	end

	`ASSERT_NEXT(a_clear_after_last, item_pop && item.last, phase_q == PH_START && mc_q == 6'd0 && next_q == '0, "search not cleared after last word")

endmodule

// ===== rtl/rtloc_result_queue.sv =====
// ----------------------------------------------------------------------------
// rtloc_result_queue
// Result queue taking up to two results per cycle, draining one per pop.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtloc_result_queue (
	input  logic clk,
	input  logic arst_n,
	input  rtloc_pkg::res_wr_t res_wr,
	output logic room2,
	input  logic pop,
	output logic empty,
	output rtloc_pkg::result_t head
);
	import rtloc_pkg::*;

	result_t mem_q [RESULT_QUEUE_DEPTH];
	logic [RESULT_PTR_W-1:0] wr_ptr_q;
	logic [RESULT_PTR_W-1:0] rd_ptr_q;
	logic [RESULT_PTR_W:0] cnt_q;
	logic rd_en;

	assign empty = cnt_q == '0;
	assign room2 = cnt_q <= (RESULT_PTR_W+1)'(RESULT_QUEUE_DEPTH - 2);
	assign rd_en = pop && !empty;
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (res_wr.count != 2'd0) begin
			mem_q[wr_ptr_q] <= res_wr.r0;
		end
		if (res_wr.count == 2'd2) begin
			mem_q[wr_ptr_q + 1'b1] <= res_wr.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + RESULT_PTR_W'(res_wr.count);
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + (RESULT_PTR_W+1)'(res_wr.count) - (RESULT_PTR_W+1)'(rd_en);
		end
	end

	`ASSERT_IMPLY(a_result_fits, res_wr.count != 2'd0, room2, "result write without room")
	`ASSERT_ALWAYS(a_result_cnt_bound, cnt_q <= (RESULT_PTR_W+1)'(RESULT_QUEUE_DEPTH), "result queue overflow")

endmodule

// ===== test/relocation_table_locator_core_tb.sv =====
// ----------------------------------------------------------------------------
// relocation_table_locator_core_tb
// Feeds images word by word and predicts table start, end and not-found
// events from a cycle-free model kept in the bench. Checks each event beat
// in order, under random idling on both sides and across register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module relocation_table_locator_core_tb;

	import rtloc_pkg::*;

	localparam int SETTLE_CYCLES = 8;
	localparam int CYCLE_LIMIT = 200000;

	typedef enum logic [1:0] {
		SEEK_START = 2'd0,
		SEEK_END = 2'd1,
		SEEK_DONE = 2'd2
	} seek_t;

	typedef enum logic [1:0] {
		REC_RELATIVE = 2'd0,
		REC_ABS = 2'd1,
		REC_LOOSE = 2'd2,
		REC_OTHER = 2'd3
	} rec_kind_t;

	typedef struct {
		logic [63:0] word;
		logic is_last;
	} image_beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [63:0] image_word = '0;
	logic last_word = 1'b0;
	logic empty;
	logic pop = 1'b0;
	ev_code_t event_code;
	logic [26:0] byte_offset;
	logic final_result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [63:0] cfg_data = '0;

	relocation_table_locator_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.image_word(image_word),
		.last_word(last_word),
		.empty(empty),
		.pop(pop),
		.event_code(event_code),
		.byte_offset(byte_offset),
		.final_result(final_result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #10 clk = ~clk;

	// scan model state
	logic [63:0] reg_floor;
	logic [5:0] reg_run_thr;
	logic [2:0] reg_gap_thr;
	logic [63:0] win [3];
	logic [24:0] words_seen;
	logic [25:0] rec_at;
	logic [5:0] run_count;
	seek_t seek;
	logic [2:0] gap_count;
	logic [25:0] gap_from;

	result_t expected_events [$];
	image_beat_t image_beats [$];
	logic [63:0] staged_words [$];
	int unsigned phase_words;
	int unsigned mismatch_count = 0;
	int unsigned cycle_count = 0;
	int unsigned send_hold;
	int unsigned take_hold;
	bit send_calm = 1'b0;
	bit take_calm = 1'b0;

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int unsigned pick_idle(input bit calm);
		return calm ? 0 : $urandom_range(0, 3);
	endfunction

	function automatic result_t make_event(input ev_code_t c, input logic [31:0] byte_pos);
		result_t e;
		e.code = c;
		e.offset = byte_pos[26:0];
		e.final_result = 1'b0;
		return e;
	endfunction

	task automatic clear_scan();
		for (int i = 0; i < 3; i++)
			win[i] = '0;
		words_seen = '0;
		rec_at = '0;
		run_count = '0;
		seek = SEEK_START;
		gap_count = '0;
		gap_from = '0;
	endtask

	task automatic scan_word(input logic [63:0] w, input logic is_last);
		result_t found [$];
		logic [63:0] addr;
		logic [63:0] kind;
		logic [63:0] addend;
		logic exact;
		logic loose;
		logic [31:0] pos;
		logic [31:0] rec;
		logic [31:0] thr;
		logic [31:0] first;
		if (words_seen < MAX_IMAGE_WORDS) begin
			pos = 32'(words_seen);
			win[0] = win[1];
			win[1] = win[2];
			win[2] = w;
			words_seen = words_seen + 1'b1;
			if (seek != SEEK_DONE && pos == 32'(rec_at) + 32'd2) begin
				addr = win[0];
				kind = win[1];
				addend = win[2];
				rec = 32'(rec_at);
				exact = (kind == TYPE_RELATIVE) || (kind == TYPE_ABS);
				loose = exact || (kind[11:0] == TYPE_ABS_LOW);
				if (seek == SEEK_START) begin
					thr = (reg_run_thr == 0) ? 32'd1 : 32'(reg_run_thr);
					if (exact) begin
						if (addr >= reg_floor && addend >= reg_floor)
							run_count = run_count + 1'b1;
					end else if (loose) begin
						run_count = run_count + 1'b1;
					end else begin
						run_count = '0;
					end
					if (32'(run_count) == thr) begin
						first = rec - (thr - 32'd1) * 32'd3;
						found.push_back(make_event(EV_START, first * 32'd8));
						seek = SEEK_END;
						gap_count = '0;
						rec_at = 26'(rec + 32'd3);
					end else begin
						rec_at = 26'(rec + ((run_count != 0) ? 32'd3 : 32'd1));
					end
				end else begin
					thr = (reg_gap_thr == 0) ? 32'd1 : 32'(reg_gap_thr);
					if (loose) begin
						gap_count = '0;
					end else begin
						if (gap_count == 0)
							gap_from = rec_at;
						gap_count = gap_count + 1'b1;
						if (32'(gap_count) >= thr) begin
							found.push_back(make_event(EV_END, 32'(gap_from) * 32'd8));
							seek = SEEK_DONE;
						end
					end
					rec_at = 26'(rec + 32'd3);
				end
			end
		end
		if (is_last) begin
			if (seek != SEEK_DONE)
				found.push_back(make_event(EV_NONE, 32'd0));
			clear_scan();
		end
		if (found.size() != 0)
			found[found.size() - 1].final_result = 1'b1;
		foreach (found[i])
			expected_events.push_back(found[i]);
	endtask

	task automatic report_mismatch(input string msg);
		$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatch_count++;
	endtask

	// word beats
	always @(posedge clk) begin : drive_words
		logic holding;
		image_beat_t nxt;
		if (!arst_n) begin
			push <= 1'b0;
			send_hold <= 0;
		end else begin
			holding = push;
			if (push && !full) begin
				scan_word(image_word, last_word);
				holding = 1'b0;
			end
			if (!holding) begin
				if (send_hold != 0) begin
					send_hold <= send_hold - 1;
					push <= 1'b0;
				end else if (image_beats.size() != 0) begin
					nxt = image_beats.pop_front();
					image_word <= nxt.word;
					last_word <= nxt.is_last;
					push <= 1'b1;
					send_hold <= pick_idle(send_calm);
				end else begin
					push <= 1'b0;
				end
			end
			if ($urandom_range(0, 40) == 0)
				send_calm <= ~send_calm;
		end
	end

	// event beats
	always @(posedge clk) begin : take_events
		int unsigned w;
		result_t want;
		if (!arst_n) begin
			pop <= 1'b0;
			take_hold <= 0;
		end else begin
			w = take_hold;
			if (pop && !empty) begin
				if (expected_events.size() == 0) begin
					report_mismatch($sformatf("unexpected event %0d offset %0d",
						event_code, byte_offset));
				end else begin
					want = expected_events.pop_front();
					if (event_code !== want.code)
						report_mismatch($sformatf("event_code %0d, want %0d",
							event_code, want.code));
					if (byte_offset !== want.offset)
						report_mismatch($sformatf("byte_offset %0d, want %0d",
							byte_offset, want.offset));
					if (final_result !== want.final_result)
						report_mismatch($sformatf("final_result %0b, want %0b",
							final_result, want.final_result));
				end
				w = pick_idle(take_calm);
			end else if (w != 0) begin
				w = w - 1;
			end
			take_hold <= w;
			pop <= (w == 0);
			if ($urandom_range(0, 47) == 0)
				take_calm <= ~take_calm;
		end
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	task automatic write_reg(input cfg_index_t idx, input logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_ADDR_FLOOR: reg_floor = value;
			CFG_RUN_THRESHOLD: reg_run_thr = value[5:0];
			CFG_GAP_LIMIT: reg_gap_thr = value[2:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(input logic [63:0] floor_addr, input logic [5:0] run_thr,
			input logic [2:0] gap_thr);
		write_reg(CFG_ADDR_FLOOR, floor_addr);
		write_reg(CFG_RUN_THRESHOLD, 64'(run_thr));
		write_reg(CFG_GAP_LIMIT, 64'(gap_thr));
	endtask

	task automatic wait_idle();
		while (image_beats.size() != 0 || push || expected_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic ship_image();
		image_beat_t b;
		foreach (staged_words[i]) begin
			b.word = staged_words[i];
			b.is_last = (i == staged_words.size() - 1);
			image_beats.push_back(b);
		end
		phase_words += staged_words.size();
		staged_words.delete();
	endtask

	function automatic logic [63:0] addr_word(input bit ok);
		if (ok || reg_floor == 0) begin
			if ($urandom_range(0, 7) == 0)
				return reg_floor;
			return reg_floor | rand64();
		end
		if ($urandom_range(0, 7) == 0)
			return reg_floor - 1;
		return rand64() & (reg_floor - 1);
	endfunction

	function automatic logic [63:0] type_word(input rec_kind_t kind);
		logic [63:0] r;
		r = rand64();
		case (kind)
			REC_RELATIVE: r = TYPE_RELATIVE;
			REC_ABS: r = TYPE_ABS;
			REC_LOOSE: r[11:0] = TYPE_ABS_LOW;
			default: begin
				if ($urandom_range(0, 3) == 0)
					r = TYPE_RELATIVE | (64'h1 << $urandom_range(12, 63));
				else if (r[11:0] == TYPE_ABS_LOW)
					r[9] = ~r[9];
			end
		endcase
		return r;
	endfunction

	task automatic stage_record(input rec_kind_t kind, input bit addr_ok, input bit addend_ok);
		staged_words.push_back(addr_word(addr_ok));
		staged_words.push_back(type_word(kind));
		staged_words.push_back(addr_word(addend_ok));
	endtask

	task automatic stage_random_image();
		int unsigned run_eff;
		int unsigned gap_eff;
		int unsigned run_len;
		int unsigned gap_len;
		int unsigned cut;
		rec_kind_t kind;
		run_eff = (reg_run_thr == 0) ? 1 : reg_run_thr;
		gap_eff = (reg_gap_thr == 0) ? 1 : reg_gap_thr;
		repeat ($urandom_range(0, 4)) staged_words.push_back(rand64());
		if ($urandom_range(0, 7) == 0) begin
			repeat ($urandom_range(1, 12)) staged_words.push_back(rand64());
		end else begin
			run_len = run_eff + $urandom_range(0, 2);
			if (run_len > 1 && $urandom_range(0, 3) == 0)
				run_len = run_len - 2;
			for (int i = 0; i < run_len; i++) begin
				case ($urandom_range(0, 15))
					0: kind = REC_OTHER;
					1, 2, 3: kind = REC_LOOSE;
					4, 5, 6, 7, 8, 9: kind = REC_RELATIVE;
					default: kind = REC_ABS;
				endcase
				stage_record(kind, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0);
			end
			gap_len = gap_eff + $urandom_range(0, 1);
			for (int i = 0; i < gap_len; i++) begin
				case ($urandom_range(0, 7))
					0: kind = REC_LOOSE;
					1: kind = REC_RELATIVE;
					default: kind = REC_OTHER;
				endcase
				stage_record(kind, $urandom_range(0, 1), $urandom_range(0, 1));
			end
			repeat ($urandom_range(0, 4)) staged_words.push_back(rand64());
			// drop the tail so the image ends mid-search
			if ($urandom_range(0, 4) == 0) begin
				cut = $urandom_range(1, staged_words.size());
				while (staged_words.size() > cut)
					void'(staged_words.pop_back());
			end
		end
		ship_image();
	endtask

	task automatic run_phase(input logic [63:0] floor_addr, input logic [5:0] run_thr,
			input logic [2:0] gap_thr, input int unsigned budget);
		wait_idle();
		set_regs(floor_addr, run_thr, gap_thr);
		phase_words = 0;
		while (phase_words < budget)
			stage_random_image();
	endtask

	initial begin : run_phases
		logic [63:0] hi;
		hi = '1;
		reg_floor = ADDR_FLOOR_RST;
		reg_run_thr = RUN_THRESHOLD_RST;
		reg_gap_thr = GAP_LIMIT_RST;
		clear_scan();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_regs(ADDR_FLOOR_RST, 6'd2, 3'd2);
		// lone last word: nothing found
		staged_words.push_back(hi);
		ship_image();
		// start at a low-address exact record, end after two misses, tail ignored
		stage_record(REC_RELATIVE, 1'b1, 1'b1);
		staged_words[0] = ADDR_FLOOR_RST;
		staged_words[2] = hi;
		staged_words.push_back(64'h0);
		staged_words.push_back(TYPE_RELATIVE);
		staged_words.push_back(hi);
		staged_words.push_back(hi);
		staged_words.push_back({52'habcde_f012_3456, TYPE_ABS_LOW});
		staged_words.push_back(64'h0);
		staged_words.push_back(64'h0);
		staged_words.push_back(64'h0);
		staged_words.push_back(64'h0);
		staged_words.push_back(64'h0);
		staged_words.push_back(64'h8000_0000_0000_0403);
		staged_words.push_back(64'h0);
		staged_words.push_back(64'h0);
		ship_image();
		// start on the last word
		staged_words.push_back(hi);
		staged_words.push_back(TYPE_ABS);
		staged_words.push_back(ADDR_FLOOR_RST);
		staged_words.push_back(hi);
		staged_words.push_back(TYPE_ABS);
		staged_words.push_back(hi);
		ship_image();

		run_phase(64'h0, 6'd1, 3'd1, 120);
		run_phase(hi, 6'd3, 3'd7, 120);
		run_phase(rand64(), 6'd0, 3'd0, 100);
		run_phase(ADDR_FLOOR_RST, 6'd63, 3'd4, 150);
		run_phase({1'b1, 63'(rand64())}, 6'($urandom_range(2, 8)),
			3'($urandom_range(1, 6)), 100);
		wait_idle();

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/rtloc_pkg.sv
rtl/rtloc_front.sv
rtl/rtloc_item_queue.sv
rtl/rtloc_back.sv
rtl/rtloc_result_queue.sv
rtl/relocation_table_locator_core.sv
test/relocation_table_locator_core_tb.sv
